@@ rtl/core/tbtp_pkg.sv @@
// ----------------------------------------------------------------------------
// Trace baseline package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tbtp_pkg;

    // Store geometry.
    localparam int NUM_BUCKETS  = 512;
    localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
    localparam int ADDR_W       = BUCKET_W + 1;
    localparam int SAMPLE_BITS  = 16;
    localparam int COUNT_W      = 10;
    localparam int SUM_W        = 26;
    localparam int DIV_CNT_W    = $clog2(SUM_W);

    // Input and output field widths.
    localparam int FUNC_W       = 2;
    localparam int TB_W         = 9;
    localparam int WORD_W       = 24;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Packed word layout.
    localparam int MAG_MAX      = 4095;
    localparam int MAG_W        = 12;
    localparam int SIGN_POS     = 12;
    localparam int BUCKET_SHIFT = 15;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_FETCH  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RENORM    = 2'd1,
        CFG_THR_EN    = 2'd2,
        CFG_DROP_ZERO = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_WR_RD,
        S_WR_UPD,
        S_DIV,
        S_FIN_RD,
        S_FIN_WR,
        S_FT_RD,
        S_FT_CHK,
        S_PUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic wr_upd;
        logic div_step;
        logic fin_wr;
        logic ft_chk;
        logic ft_end;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic addr_last;
        logic addr_end;
        logic div_last;
        logic fetchable;
        logic found;
    } t_stat;

endpackage

@@ rtl/core/tbtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trace baseline controller
// Sequences writes, division, finish sweep, fetch scan and clearing pass.
// ----------------------------------------------------------------------------
module tbtp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [tbtp_pkg::FUNC_W-1:0] i_func,
    input  logic                       i_out_ready,
    input  tbtp_pkg::t_stat            i_stat,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    output tbtp_pkg::t_cmd             o_cmd
);

    tbtp_pkg::t_state r_state, n_state;
    logic             r_from_cmd, n_from_cmd;
    logic             r_out_valid, n_out_valid;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbtp_pkg::S_CLR;
            r_from_cmd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_from_cmd  <= n_from_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_from_cmd  = r_from_cmd;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tbtp_pkg::S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = r_from_cmd ? tbtp_pkg::S_PUSH : tbtp_pkg::S_IDLE;
                end
            end
            tbtp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (tbtp_pkg::t_func'(i_func))
                        tbtp_pkg::FUNC_WRITE:  n_state = tbtp_pkg::S_WR_RD;
                        tbtp_pkg::FUNC_FINISH: begin
                            n_state = i_stat.count_zero ? tbtp_pkg::S_PUSH
                                                        : tbtp_pkg::S_DIV;
                        end
                        tbtp_pkg::FUNC_FETCH:  n_state = tbtp_pkg::S_FT_RD;
                        tbtp_pkg::FUNC_CLEAR: begin
                            n_state    = tbtp_pkg::S_CLR;
                            n_from_cmd = 1'b1;
                        end
                        default: n_state = tbtp_pkg::S_IDLE;
                    endcase
                end
            end
            tbtp_pkg::S_WR_RD:  n_state = tbtp_pkg::S_WR_UPD;
            tbtp_pkg::S_WR_UPD: begin
                o_cmd.wr_upd = 1'b1;
                n_state      = tbtp_pkg::S_PUSH;
            end
            tbtp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = tbtp_pkg::S_FIN_RD;
                end
            end
            tbtp_pkg::S_FIN_RD: n_state = tbtp_pkg::S_FIN_WR;
            tbtp_pkg::S_FIN_WR: begin
                o_cmd.fin_wr = 1'b1;
                n_state = i_stat.addr_last ? tbtp_pkg::S_PUSH : tbtp_pkg::S_FIN_RD;
            end
            tbtp_pkg::S_FT_RD: begin
                if (i_stat.addr_end) begin
                    o_cmd.ft_end = 1'b1;
                    n_state      = tbtp_pkg::S_PUSH;
                end else begin
                    n_state = tbtp_pkg::S_FT_CHK;
                end
            end
            tbtp_pkg::S_FT_CHK: begin
                o_cmd.ft_chk = 1'b1;
                // A second fetchable entry means more words remain.
                n_state = (i_stat.fetchable && i_stat.found) ? tbtp_pkg::S_PUSH
                                                             : tbtp_pkg::S_FT_RD;
            end
            tbtp_pkg::S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_from_cmd  = 1'b0;
                    n_state     = tbtp_pkg::S_IDLE;
                end
            end
            default: n_state = tbtp_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/tbtp_dp.sv @@
// ----------------------------------------------------------------------------
// Trace baseline datapath
// Sample store, running sum, mean divider, conditioning and word packing.
// ----------------------------------------------------------------------------
module tbtp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tbtp_pkg::t_cmd                    i_cmd,
    input  logic [tbtp_pkg::FUNC_W-1:0]       i_func,
    input  logic [tbtp_pkg::TB_W-1:0]         i_time_bucket,
    input  logic signed [tbtp_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic                              i_cfg_we,
    input  logic [tbtp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbtp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tbtp_pkg::t_stat                   o_stat,
    output logic [tbtp_pkg::WORD_W-1:0]       o_packed_word,
    output logic                              o_word_valid,
    output logic                              o_last_word,
    output logic [tbtp_pkg::STATUS_W-1:0]     o_status
);

    localparam int SB   = tbtp_pkg::SAMPLE_BITS;
    localparam int AW   = tbtp_pkg::ADDR_W;
    localparam int BW   = tbtp_pkg::BUCKET_W;
    localparam int CW   = tbtp_pkg::COUNT_W;
    localparam int SW   = tbtp_pkg::SUM_W;
    localparam int DW   = SW + 1;
    localparam int MW   = SB + 1;

    // Store entry: present flag over the sample.
    logic [SB:0]              mem [tbtp_pkg::NUM_BUCKETS];
    logic [SB:0]              r_rd;
    logic                     mem_we;
    logic [SB:0]              mem_wdata;

    logic [AW-1:0]            r_addr;
    logic signed [SB-1:0]     r_sv;
    logic                     r_wr_ok;
    logic [CW-1:0]            r_count;
    logic signed [SW-1:0]     r_sum;
    logic signed [SW-1:0]     r_total;
    logic [AW-1:0]            r_fp;
    logic                     r_found;

    logic signed [SB-1:0]     r_thr;
    logic                     r_renorm;
    logic                     r_thr_en;
    logic                     r_drop;

    logic [SW-1:0]            r_dq;
    logic [CW-1:0]            r_rem;
    logic                     r_neg;
    logic [tbtp_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic [tbtp_pkg::WORD_W-1:0]   r_res_word;
    logic                          r_res_wv;
    logic                          r_res_last;
    logic [tbtp_pkg::STATUS_W-1:0] r_res_status;

    logic [tbtp_pkg::WORD_W-1:0]   r_out_word;
    logic                          r_out_wv;
    logic                          r_out_last;
    logic [tbtp_pkg::STATUS_W-1:0] r_out_status;

    logic                     rd_present;
    logic signed [SB-1:0]     rd_value;
    logic [CW:0]              rem_sh;
    logic signed [SW-1:0]     mean;
    logic signed [DW-1:0]     diff;
    logic signed [SB-1:0]     fin_v;
    logic signed [SW-1:0]     total_next;
    logic [MW-1:0]            mag_raw;
    logic [tbtp_pkg::MAG_W-1:0] mag;
    logic [tbtp_pkg::WORD_W-1:0] pack;

    localparam logic signed [DW-1:0] SMAX = DW'((1 <<< (SB - 1)) - 1);
    localparam logic signed [DW-1:0] SMIN = -DW'(1 <<< (SB - 1));

    assign rd_present = r_rd[SB];
    assign rd_value   = r_rd[SB-1:0];

    // Status toward the controller.
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.addr_last  = (r_addr == AW'(tbtp_pkg::NUM_BUCKETS - 1));
    assign o_stat.addr_end   = (r_addr == AW'(tbtp_pkg::NUM_BUCKETS));
    assign o_stat.div_last   = (r_div_cnt == tbtp_pkg::DIV_CNT_W'(SW - 1));
    assign o_stat.fetchable  = rd_present && !(r_drop && (rd_value == '0));
    assign o_stat.found      = r_found;

    // Divider step: shift one dividend bit into the partial remainder.
    assign rem_sh = {r_rem, r_dq[SW-1]};

    // Truncated mean, signed by the sum's sign; zero when renormalisation is off.
    always_comb begin
        if (!r_renorm) begin
            mean = '0;
        end else if (r_neg) begin
            mean = -$signed(r_dq);
        end else begin
            mean = $signed(r_dq);
        end
    end

    // Baseline subtraction, saturation and threshold.
    always_comb begin
        diff = DW'(rd_value) - DW'(mean);
        if (diff > SMAX) begin
            fin_v = SB'(SMAX);
        end else if (diff < SMIN) begin
            fin_v = SB'(SMIN);
        end else begin
            fin_v = diff[SB-1:0];
        end
        if (r_thr_en && (fin_v < r_thr)) begin
            fin_v = '0;
        end
        total_next = rd_present ? (r_total + SW'(fin_v)) : r_total;
    end

    // Word packing with magnitude saturation for both signs.
    always_comb begin
        mag_raw = rd_value[SB-1] ? MW'(-MW'(rd_value)) : MW'(rd_value);
        mag     = (mag_raw >= MW'(tbtp_pkg::MAG_MAX)) ? tbtp_pkg::MAG_W'(tbtp_pkg::MAG_MAX)
                                                      : mag_raw[tbtp_pkg::MAG_W-1:0];
        pack    = '0;
        pack[tbtp_pkg::BUCKET_SHIFT +: BW] = r_addr[BW-1:0];
        pack[tbtp_pkg::SIGN_POS]           = rd_value[SB-1];
        pack[tbtp_pkg::MAG_W-1:0]          = mag;
    end

    // Memory write port.
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (i_cmd.clr_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.wr_upd) begin
            mem_we    = r_wr_ok;
            mem_wdata = {1'b1, r_sv};
        end else if (i_cmd.fin_wr) begin
            mem_we    = rd_present;
            mem_wdata = {1'b1, fin_v};
        end
    end

    // Sample store with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr[BW-1:0]] <= mem_wdata;
        end
        r_rd <= mem[r_addr[BW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_renorm <= 1'b1;
            r_thr_en <= 1'b1;
            r_drop   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (tbtp_pkg::t_cfg_idx'(i_cfg_index))
                tbtp_pkg::CFG_THRESHOLD: r_thr    <= SB'(i_cfg_data);
                tbtp_pkg::CFG_RENORM:    r_renorm <= i_cfg_data[0];
                tbtp_pkg::CFG_THR_EN:    r_thr_en <= i_cfg_data[0];
                tbtp_pkg::CFG_DROP_ZERO: r_drop   <= i_cfg_data[0];
                default: r_drop <= r_drop;
            endcase
        end
    end

    // Trace state, address walker and pending result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_fp    <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_res_word   <= '0;
                r_res_wv     <= 1'b0;
                r_res_last   <= 1'b0;
                r_res_status <= tbtp_pkg::ST_OK;
                r_found      <= 1'b0;
                unique case (tbtp_pkg::t_func'(i_func))
                    tbtp_pkg::FUNC_WRITE: begin
                        r_addr <= AW'(i_time_bucket);
                    end
                    tbtp_pkg::FUNC_FINISH: begin
                        r_addr <= '0;
                        if (r_count == '0) begin
                            r_res_status <= tbtp_pkg::ST_EMPTY;
                        end
                    end
                    tbtp_pkg::FUNC_FETCH: begin
                        r_addr <= r_fp;
                    end
                    tbtp_pkg::FUNC_CLEAR: begin
                        r_addr  <= '0;
                        r_count <= '0;
                        r_sum   <= '0;
                        r_fp    <= '0;
                    end
                    default: r_addr <= r_addr;
                endcase
            end
            if (i_cmd.clr_wr || i_cmd.fin_wr || i_cmd.ft_chk) begin
                r_addr <= r_addr + AW'(1);
            end
            // Rewrite replaces the old sample in the sum.
            if (i_cmd.wr_upd && r_wr_ok) begin
                if (rd_present) begin
                    r_sum <= r_sum + SW'(r_sv) - SW'(rd_value);
                end else begin
                    r_sum   <= r_sum + SW'(r_sv);
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.fin_wr && o_stat.addr_last) begin
                r_sum <= total_next;
                r_fp  <= '0;
            end
            if (i_cmd.ft_chk && o_stat.fetchable && !r_found) begin
                r_found    <= 1'b1;
                r_res_word <= pack;
                r_res_wv   <= 1'b1;
                r_fp       <= r_addr + AW'(1);
            end
            if (i_cmd.ft_end) begin
                r_res_last <= 1'b1;
                if (!r_found) begin
                    r_res_status <= tbtp_pkg::ST_NONE;
                    r_fp         <= AW'(tbtp_pkg::NUM_BUCKETS);
                end
            end
        end
    end

    // Input capture, divider and finish accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sv      <= i_sample_value;
            r_wr_ok   <= ({1'b0, i_time_bucket} < (tbtp_pkg::TB_W + 1)'(tbtp_pkg::NUM_BUCKETS));
            r_dq      <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
            r_neg     <= r_sum[SW-1];
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_total   <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + tbtp_pkg::DIV_CNT_W'(1);
            if (rem_sh >= {1'b0, r_count}) begin
                r_rem <= CW'(rem_sh - {1'b0, r_count});
                r_dq  <= {r_dq[SW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CW-1:0];
                r_dq  <= {r_dq[SW-2:0], 1'b0};
            end
        end
        if (i_cmd.fin_wr) begin
            r_total <= total_next;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_word   <= r_res_word;
            r_out_wv     <= r_res_wv;
            r_out_last   <= r_res_last;
            r_out_status <= r_res_status;
        end
    end

    assign o_packed_word = r_out_word;
    assign o_word_valid  = r_out_wv;
    assign o_last_word   = r_out_last;
    assign o_status      = r_out_status;

endmodule

@@ rtl/core/trace_baseline_threshold_pack.sv @@
// ----------------------------------------------------------------------------
// Trace baseline threshold pack
// Sparse sample trace with mean baseline removal, threshold and word fetch.
// ----------------------------------------------------------------------------
// One command word is taken at a time and each gives one result word. After
// reset the store is swept clear before the first command is taken. A sample
// write passes through a store read, an update and a handoff. A finish runs
// the divider for the mean, then reads all 512 buckets and rewrites the
// present ones; with an empty store it goes straight to the handoff. A fetch
// reads and checks each bucket it examines. A clear runs the same sweep as
// reset. These steps follow from the store's single read/write port. A new
// command is taken while the previous result is still waiting.
module trace_baseline_threshold_pack (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [tbtp_pkg::FUNC_W-1:0]              i_func,
    input  logic [tbtp_pkg::TB_W-1:0]                i_time_bucket,
    input  logic signed [tbtp_pkg::SAMPLE_BITS-1:0]  i_sample_value,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [tbtp_pkg::WORD_W-1:0]              o_packed_word,
    output logic                                     o_word_valid,
    output logic                                     o_last_word,
    output logic [tbtp_pkg::STATUS_W-1:0]            o_status,
    input  logic                                     i_cfg_we,
    input  logic [tbtp_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [tbtp_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    tbtp_pkg::t_cmd  cmd;
    tbtp_pkg::t_stat stat;

    // Controller.
    tbtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Datapath.
    tbtp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_time_bucket  (i_time_bucket),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (stat),
        .o_packed_word  (o_packed_word),
        .o_word_valid   (o_word_valid),
        .o_last_word    (o_last_word),
        .o_status       (o_status)
    );

endmodule

@@ rtl/core/tbtp_checker.sv @@
// ----------------------------------------------------------------------------
// Trace baseline port checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
module tbtp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [tbtp_pkg::WORD_W-1:0]         o_packed_word,
    input logic                                o_word_valid,
    input logic                                o_last_word,
    input logic [tbtp_pkg::STATUS_W-1:0]       o_status
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_packed_word))
        else $error("result word changed while stalled");

    // A word without a fetched entry is all zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_valid |-> o_packed_word == '0)
        else $error("packed word nonzero without entry");

    // An exhausted fetch is marked last and carries no entry.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == tbtp_pkg::ST_NONE |-> o_last_word && !o_word_valid)
        else $error("exhausted fetch flags wrong");

    // A fetched entry always reports ok.
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid |-> o_status == tbtp_pkg::ST_OK)
        else $error("fetched entry with error status");

endmodule

bind trace_baseline_threshold_pack tbtp_checker u_tbtp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_packed_word (o_packed_word),
    .o_word_valid  (o_word_valid),
    .o_last_word   (o_last_word),
    .o_status      (o_status)
);
